/* rtl/s2sl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_pkg
// Shared constants, types and tables for the square Lambert projection.
// ----------------------------------------------------------------------------
package s2sl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IO_W      = 18;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_NORM_TOL = 2'd0;
    localparam logic [IDX_W-1:0] REG_POLE_TOL = 2'd1;

    // CORDIC
    localparam int CORDIC_N = 30;
    localparam int ANG_W    = 33;
    localparam int CXY_W    = 52;
    localparam int ANG_FRAC = 30;
    localparam int STG_W    = 5;

    // square root: n = d << F, d <= 2^F
    localparam int SQ_W     = 2 * FRAC_BITS + 2;
    localparam int SQ_ITERS = FRAC_BITS + 1;
    localparam int M_W      = FRAC_BITS + 1;

    // squared norm scale
    localparam int SUM_W    = ((2 * FRAC_BITS + 1) > 36 ? (2 * FRAC_BITS + 1) : 36) + 1;
    localparam int NORM_SHL = (2 * FRAC_BITS >= 32) ? (2 * FRAC_BITS - 32) : 0;
    localparam int NORM_SHR = (2 * FRAC_BITS < 32) ? (32 - 2 * FRAC_BITS) : 0;

    localparam logic signed [IO_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [IO_W-1:0] OUT_MIN = -18'sd131072;

    // one beat in flight through the cell row
    typedef struct packed {
        logic                    valid;
        logic                    err;
        logic                    zero;
        logic                    swap;
        logic                    neg;
        logic [SQ_W-1:0]         sq_n;
        logic [SQ_W-1:0]         sq_r;
        logic signed [CXY_W-1:0] cx;
        logic signed [CXY_W-1:0] cy;
        logic signed [ANG_W-1:0] acc;
    } cell_t;

    // atan(2^-i) in units of 2^-30 of pi/4
    function automatic logic signed [ANG_W-1:0] ang_tab(input logic [STG_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                5'd0:  r = 33'sd1073741824;
                5'd1:  r = 33'sd633866811;
                5'd2:  r = 33'sd334917815;
                5'd3:  r = 33'sd170009512;
                5'd4:  r = 33'sd85334662;
                5'd5:  r = 33'sd42708931;
                5'd6:  r = 33'sd21359677;
                5'd7:  r = 33'sd10680490;
                5'd8:  r = 33'sd5340327;
                5'd9:  r = 33'sd2670173;
                5'd10: r = 33'sd1335088;
                5'd11: r = 33'sd667544;
                5'd12: r = 33'sd333772;
                5'd13: r = 33'sd166886;
                5'd14: r = 33'sd83443;
                5'd15: r = 33'sd41722;
                5'd16: r = 33'sd20861;
                5'd17: r = 33'sd10430;
                5'd18: r = 33'sd5215;
                5'd19: r = 33'sd2608;
                5'd20: r = 33'sd1304;
                5'd21: r = 33'sd652;
                5'd22: r = 33'sd326;
                5'd23: r = 33'sd163;
                5'd24: r = 33'sd81;
                5'd25: r = 33'sd41;
                5'd26: r = 33'sd20;
                5'd27: r = 33'sd10;
                5'd28: r = 33'sd5;
                5'd29: r = 33'sd3;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/s2sl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_if
// Valid/ready channels for direction beats and result beats.
// ----------------------------------------------------------------------------
interface s2sl_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [s2sl_pkg::IO_W-1:0] dir_x;
    logic signed [s2sl_pkg::IO_W-1:0] dir_y;
    logic signed [s2sl_pkg::IO_W-1:0] dir_z;

    modport source (output valid, dir_x, dir_y, dir_z, input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, output ready);
endinterface

interface s2sl_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [s2sl_pkg::IO_W-1:0] square_u;
    logic signed [s2sl_pkg::IO_W-1:0] square_v;
    logic                            off_sphere;

    modport source (output valid, square_u, square_v, off_sphere, input ready);
    modport sink   (input valid, square_u, square_v, off_sphere, output ready);
endinterface

/* rtl/s2sl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_front
// Norm and pole checks, branch select, and loading of the cell row.
// ----------------------------------------------------------------------------
module s2sl_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic signed [s2sl_pkg::IO_W-1:0]  dir_x,
    input  logic signed [s2sl_pkg::IO_W-1:0]  dir_y,
    input  logic signed [s2sl_pkg::IO_W-1:0]  dir_z,
    input  logic [s2sl_pkg::CFG_W-1:0]        norm_tol,
    input  logic [s2sl_pkg::CFG_W-1:0]        pole_tol,
    output s2sl_pkg::cell_t                   cell_out
);

    localparam int IO_W  = s2sl_pkg::IO_W;
    localparam int SUM_W = s2sl_pkg::SUM_W;
    localparam int SQ_W  = s2sl_pkg::SQ_W;
    localparam int CXY_W = s2sl_pkg::CXY_W;
    localparam int F     = s2sl_pkg::FRAC_BITS;

    // stage 1: squares and magnitudes
    logic                   v1_reg;
    logic signed [IO_W-1:0] x1_reg, y1_reg;
    logic [IO_W:0]          ax1_reg, ay1_reg, az1_reg;
    logic [2*IO_W-1:0]      xx1_reg, yy1_reg, zz1_reg;

    function automatic logic [IO_W:0] absv(input logic signed [IO_W-1:0] a);
        logic signed [IO_W:0] e;
        begin
            e = {a[IO_W-1], a};
            return a[IO_W-1] ? (IO_W+1)'(0) - e : e;
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg  <= dir_x;
            y1_reg  <= dir_y;
            ax1_reg <= absv(dir_x);
            ay1_reg <= absv(dir_y);
            az1_reg <= absv(dir_z);
            xx1_reg <= (2*IO_W)'(dir_x) * (2*IO_W)'(dir_x);
            yy1_reg <= (2*IO_W)'(dir_y) * (2*IO_W)'(dir_y);
            zz1_reg <= (2*IO_W)'(dir_z) * (2*IO_W)'(dir_z);
        end
    end

    // stage 2: checks and cell row load
    logic [SUM_W-1:0]        sum, one2, dev, tol;
    logic signed [IO_W+2:0]  pdiff;
    logic [IO_W+1:0]         pdev;
    logic [F:0]              d;
    logic                    swap, neg, err, zero;
    logic signed [IO_W-1:0]  major, minor;
    logic [IO_W:0]           major_abs;
    logic signed [IO_W:0]    minor_s;
    s2sl_pkg::cell_t         nxt;

    always_comb
    begin
        sum  = SUM_W'(xx1_reg) + SUM_W'(yy1_reg) + SUM_W'(zz1_reg);
        one2 = SUM_W'(1) << (2 * F);
        dev  = (sum >= one2) ? sum - one2 : one2 - sum;
        tol  = (SUM_W'(norm_tol) << s2sl_pkg::NORM_SHL) >> s2sl_pkg::NORM_SHR;
        err  = dev > tol;

        pdiff = (IO_W+3)'(signed'({2'b00, az1_reg})) - ((IO_W+3)'(1) <<< F);
        pdev  = pdiff[IO_W+2] ? (IO_W+2)'(-pdiff) : (IO_W+2)'(pdiff);
        zero  = (pdev <= (IO_W+2)'(pole_tol)) || (x1_reg == '0 && y1_reg == '0);

        // 1 - |z| clamped at zero
        d = pdiff[IO_W+2] ? (F+1)'(-pdiff) : '0;

        swap      = ay1_reg > ax1_reg;
        major     = swap ? y1_reg : x1_reg;
        minor     = swap ? x1_reg : y1_reg;
        major_abs = swap ? ay1_reg : ax1_reg;
        neg       = major[IO_W-1];
        minor_s   = neg ? -(IO_W+1)'(minor) : (IO_W+1)'(minor);

        nxt.valid = v1_reg;
        nxt.err   = err;
        nxt.zero  = zero;
        nxt.swap  = swap;
        nxt.neg   = neg;
        nxt.sq_n  = SQ_W'(d) << F;
        nxt.sq_r  = '0;
        nxt.cx    = signed'(CXY_W'(major_abs)) <<< s2sl_pkg::ANG_FRAC;
        nxt.cy    = CXY_W'(minor_s) <<< s2sl_pkg::ANG_FRAC;
        nxt.acc   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_out <= '0;
        end
        else if (adv)
        begin
            cell_out <= nxt;
        end
    end

endmodule

/* rtl/s2sl_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_cell
// One CORDIC vectoring step and, below SQ_ITERS, one square root digit, registered.
// ----------------------------------------------------------------------------
module s2sl_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic [s2sl_pkg::STG_W-1:0]        stage_idx,
    input  s2sl_pkg::cell_t                   cell_in,
    output s2sl_pkg::cell_t                   cell_out
);

    localparam int SQ_W  = s2sl_pkg::SQ_W;
    localparam int CXY_W = s2sl_pkg::CXY_W;
    localparam int F     = s2sl_pkg::FRAC_BITS;

    logic signed [CXY_W-1:0] dx, dy;
    logic [SQ_W-1:0]         sbit, trial;
    s2sl_pkg::cell_t         nxt;

    always_comb
    begin
        nxt = cell_in;

        // rotate toward the x axis
        dx = cell_in.cy >>> stage_idx;
        dy = cell_in.cx >>> stage_idx;
        if (!cell_in.cy[CXY_W-1])
        begin
            nxt.cx  = cell_in.cx + dx;
            nxt.cy  = cell_in.cy - dy;
            nxt.acc = cell_in.acc + s2sl_pkg::ang_tab(stage_idx);
        end
        else
        begin
            nxt.cx  = cell_in.cx - dx;
            nxt.cy  = cell_in.cy + dy;
            nxt.acc = cell_in.acc - s2sl_pkg::ang_tab(stage_idx);
        end

        // restoring square root, one result bit per cell below SQ_ITERS
        sbit  = SQ_W'(1) << (2 * F - 2 * int'(stage_idx));
        trial = cell_in.sq_r + sbit;
        if (int'(stage_idx) < s2sl_pkg::SQ_ITERS)
        begin
            if (cell_in.sq_n >= trial)
            begin
                nxt.sq_n = cell_in.sq_n - trial;
                nxt.sq_r = (cell_in.sq_r >> 1) + sbit;
            end
            else
            begin
                nxt.sq_r = cell_in.sq_r >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_out <= '0;
        end
        else if (adv)
        begin
            cell_out <= nxt;
        end
    end

endmodule

/* rtl/s2sl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_back
// Angle scaling by the radius, sign, placement, and the output register.
// ----------------------------------------------------------------------------
module s2sl_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  s2sl_pkg::cell_t                   cell_in,
    output logic                              out_valid,
    output logic signed [s2sl_pkg::IO_W-1:0]  square_u,
    output logic signed [s2sl_pkg::IO_W-1:0]  square_v,
    output logic                              off_sphere
);

    localparam int IO_W  = s2sl_pkg::IO_W;
    localparam int M_W   = s2sl_pkg::M_W;
    localparam int ANG_W = s2sl_pkg::ANG_W;
    localparam int AF    = s2sl_pkg::ANG_FRAC;
    localparam int P_W   = M_W + AF + 1;
    localparam int W_W   = M_W + 3;

    // stage 1: clamp angle, multiply
    logic signed [ANG_W-1:0] ang;
    logic [AF:0]             ang_abs;
    logic [M_W-1:0]          m;

    always_comb
    begin
        ang = cell_in.acc;
        if (ang > (ANG_W'(1) <<< AF))
        begin
            ang = ANG_W'(1) <<< AF;
        end
        else if (ang < -(ANG_W'(1) <<< AF))
        begin
            ang = -(ANG_W'(1) <<< AF);
        end
        ang_abs = ang[ANG_W-1] ? (AF+1)'(-ang) : (AF+1)'(ang);
        m       = cell_in.sq_r[M_W-1:0];
    end

    logic           v1_reg, err1_reg, zero1_reg, swap1_reg, neg1_reg, aneg1_reg;
    logic [M_W-1:0] m1_reg;
    logic [P_W-1:0] prod1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err1_reg  <= cell_in.err;
            zero1_reg <= cell_in.zero;
            swap1_reg <= cell_in.swap;
            neg1_reg  <= cell_in.neg;
            aneg1_reg <= ang[ANG_W-1];
            m1_reg    <= m;
            prod1_reg <= P_W'(m) * P_W'(ang_abs);
        end
    end

    // stage 2: round, sign, saturate
    function automatic logic signed [IO_W-1:0] sat(input logic signed [W_W-1:0] a);
        begin
            if (a > W_W'(s2sl_pkg::OUT_MAX))
            begin
                return s2sl_pkg::OUT_MAX;
            end
            else if (a < W_W'(s2sl_pkg::OUT_MIN))
            begin
                return s2sl_pkg::OUT_MIN;
            end
            return IO_W'(a);
        end
    endfunction

    logic [P_W-1:0]        rnd;
    logic signed [W_W-1:0] mag, other, major;
    logic signed [IO_W-1:0] u_next, v_next;

    always_comb
    begin
        rnd   = (prod1_reg + (P_W'(1) << (AF - 1))) >> AF;
        mag   = signed'(W_W'(rnd));
        other = (aneg1_reg ^ neg1_reg) ? -mag : mag;
        major = neg1_reg ? -signed'(W_W'(m1_reg)) : signed'(W_W'(m1_reg));
        if (err1_reg || zero1_reg)
        begin
            u_next = '0;
            v_next = '0;
        end
        else if (swap1_reg)
        begin
            u_next = sat(other);
            v_next = sat(major);
        end
        else
        begin
            u_next = sat(major);
            v_next = sat(other);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            square_u   <= u_next;
            square_v   <= v_next;
            off_sphere <= err1_reg;
        end
    end

endmodule

/* rtl/sphere_to_square_lambert_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_to_square_lambert_top
// Square Lambert equal-area projection of a unit direction, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  in_ch     in    dir_x, dir_y, dir_z (signed Q2.16)
//  out_ch    out   square_u, square_v (signed Q2.16), off_sphere
//  cfg       in    cfg_we, cfg_index, cfg_data (norm / pole tolerance)
//
//  One beat per cycle while out_ch does not stall; 2 check stages, 30 cells
//  (CORDIC step each, square root digit in the first SQ_ITERS), multiply
//  and output stages. The whole row advances together; an out_ch stall
//  holds every stage. Reset clears valid bits and loads tolerances 1 and 0.
// ----------------------------------------------------------------------------
module sphere_to_square_lambert_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [s2sl_pkg::IDX_W-1:0]        cfg_index,
    input  logic [s2sl_pkg::CFG_W-1:0]        cfg_data,
    s2sl_in_if.sink                           in_ch,
    s2sl_out_if.source                        out_ch
);

    localparam int N = s2sl_pkg::CORDIC_N;

    logic [s2sl_pkg::CFG_W-1:0] norm_tol_reg, pole_tol_reg;
    logic                       adv;
    s2sl_pkg::cell_t            chain [0:N];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_tol_reg <= s2sl_pkg::CFG_W'(1);
            pole_tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                s2sl_pkg::REG_NORM_TOL: norm_tol_reg <= cfg_data;
                s2sl_pkg::REG_POLE_TOL: pole_tol_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline moves unless the output beat is stuck
    assign adv         = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = adv;

    s2sl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_ch.valid),
        .dir_x    (in_ch.dir_x),
        .dir_y    (in_ch.dir_y),
        .dir_z    (in_ch.dir_z),
        .norm_tol (norm_tol_reg),
        .pole_tol (pole_tol_reg),
        .cell_out (chain[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        s2sl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .stage_idx (s2sl_pkg::STG_W'(i)),
            .cell_in   (chain[i]),
            .cell_out  (chain[i+1])
        );
    end

    s2sl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .cell_in    (chain[N]),
        .out_valid  (out_ch.valid),
        .square_u   (out_ch.square_u),
        .square_v   (out_ch.square_v),
        .off_sphere (out_ch.off_sphere)
    );

endmodule

/* rtl/s2sl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2sl_checker
// Port-level checks on the projection block.
// ----------------------------------------------------------------------------
module s2sl_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [s2sl_pkg::IO_W-1:0]  square_u,
    input logic signed [s2sl_pkg::IO_W-1:0]  square_v,
    input logic                              off_sphere
);

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(square_u)
            && $stable(square_v) && $stable(off_sphere))
        else $error("result beat changed under stall");

    // off-sphere results are zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && off_sphere |-> square_u == '0 && square_v == '0)
        else $error("off_sphere with nonzero coordinates");

    // input only blocked by a stuck output
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready mismatch");

endmodule

bind sphere_to_square_lambert_top s2sl_checker u_s2sl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .square_u   (out_ch.square_u),
    .square_v   (out_ch.square_v),
    .off_sphere (out_ch.off_sphere)
);

/* bench/tb_lambert_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lambert_checker
// Watches the direction and result channels and the register port, predicts
// the square Lambert coordinates of each accepted direction and compares
// them, in order, with the result beats.
// ----------------------------------------------------------------------------
module tb_lambert_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [s2sl_pkg::IDX_W-1:0]    cfg_index,
    input  logic [s2sl_pkg::CFG_W-1:0]    cfg_data,
    s2sl_in_if                            in_ch,
    s2sl_out_if                           out_ch,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            off_count
);

    localparam int IO_W = s2sl_pkg::IO_W;
    localparam int FB   = s2sl_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [IO_W-1:0] u;
        logic signed [IO_W-1:0] v;
        logic                   off;
    } lambert_t;

    localparam longint ONE   = 64'sd1 << FB;
    localparam longint ONE2  = 64'sd1 << (2 * FB);
    localparam longint A_ONE = 64'sd1 << 30;

    // atan(2^-i) in units of 2^-30 of pi/4
    localparam longint ATAN_STEP [30] = '{
        1073741824, 633866811, 334917815, 170009512, 85334662, 42708931,
        21359677, 10680490, 5340327, 2670173, 1335088, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
        163, 81, 41, 20, 10, 5, 3
    };

    logic [s2sl_pkg::CFG_W-1:0] norm_tol;
    logic [s2sl_pkg::CFG_W-1:0] pole_tol;
    lambert_t                   coord_q[$];

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // (4/pi)*atan(b/a), a > 0, by vectoring rotations; clamped to +-1
    function automatic longint atan_scaled(input longint a, input longint b);
        longint cx, cy, acc, tx, ty;
        begin
            cx  = a * A_ONE;
            cy  = b * A_ONE;
            acc = 0;
            for (int i = 0; i < 30; i++)
            begin
                tx = cy >>> i;
                ty = cx >>> i;
                if (cy >= 0)
                begin
                    cx  = cx + tx;
                    cy  = cy - ty;
                    acc = acc + ATAN_STEP[i];
                end
                else
                begin
                    cx  = cx - tx;
                    cy  = cy + ty;
                    acc = acc - ATAN_STEP[i];
                end
            end
            if (acc > A_ONE)
                acc = A_ONE;
            if (acc < -A_ONE)
                acc = -A_ONE;
            return acc;
        end
    endfunction

    function automatic longint clip_io(input longint a);
        begin
            if (a > 131071)
                return 131071;
            if (a < -131072)
                return -131072;
            return a;
        end
    endfunction

    function automatic lambert_t project_dir(input logic signed [IO_W-1:0] dx,
                                             input logic signed [IO_W-1:0] dy,
                                             input logic signed [IO_W-1:0] dz);
        lambert_t        r;
        longint          x, y, z, ax, ay, az, sum, dev, tol, pdev, d, m, s;
        longint          major, minor, ang, other, u, v;
        longint unsigned mag;
        begin
            x   = dx;
            y   = dy;
            z   = dz;
            ax  = x < 0 ? -x : x;
            ay  = y < 0 ? -y : y;
            az  = z < 0 ? -z : z;
            sum = x * x + y * y + z * z;
            dev = sum >= ONE2 ? sum - ONE2 : ONE2 - sum;
            tol = (longint'(norm_tol) << s2sl_pkg::NORM_SHL) >>> s2sl_pkg::NORM_SHR;
            pdev = ONE >= az ? ONE - az : az - ONE;
            u = 0;
            v = 0;
            r.off = 1'b0;
            if (dev > tol)
                r.off = 1'b1;
            else if (pdev > longint'(pole_tol) && !(x == 0 && y == 0))
            begin
                d = ONE - az;
                if (d < 0)
                    d = 0;
                m = root_floor(longint'(d) << FB);
                if (ay <= ax)
                begin
                    major = x;
                    minor = y;
                end
                else
                begin
                    major = y;
                    minor = x;
                end
                s   = major < 0 ? -1 : 1;
                ang = atan_scaled(major < 0 ? -major : major, minor * s);
                mag = (longint'(m) * (ang < 0 ? -ang : ang) + (64'd1 << 29)) >> 30;
                other = (ang < 0 ? -longint'(mag) : longint'(mag)) * s;
                if (ay <= ax)
                begin
                    u = s * m;
                    v = other;
                end
                else
                begin
                    u = other;
                    v = s * m;
                end
            end
            r.u = IO_W'(clip_io(u));
            r.v = IO_W'(clip_io(v));
            return r;
        end
    endfunction

    // register shadow, predict on each direction beat, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        lambert_t want;
        int       errs;
        errs = 0;
        if (!rst_n)
        begin
            norm_tol   <= 16'd1;
            pole_tol   <= 16'd0;
            fail_count <= 0;
            checked    <= 0;
            off_count  <= 0;
            pending    <= 0;
            coord_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == s2sl_pkg::REG_NORM_TOL)
                    norm_tol <= cfg_data;
                else if (cfg_index == s2sl_pkg::REG_POLE_TOL)
                    pole_tol <= cfg_data;
            end
            if (in_ch.valid && in_ch.ready)
                coord_q.push_back(project_dir(in_ch.dir_x, in_ch.dir_y, in_ch.dir_z));
            if (out_ch.valid && out_ch.ready)
            begin
                if (coord_q.size() == 0)
                begin
                    $error("result beat with no direction outstanding");
                    errs++;
                end
                else
                begin
                    want = coord_q.pop_front();
                    checked <= checked + 1;
                    if (want.off)
                        off_count <= off_count + 1;
                    if (out_ch.square_u !== want.u)
                    begin
                        $error("square_u: expected %0d, got %0d", want.u, out_ch.square_u);
                        errs++;
                    end
                    if (out_ch.square_v !== want.v)
                    begin
                        $error("square_v: expected %0d, got %0d", want.v, out_ch.square_v);
                        errs++;
                    end
                    if (out_ch.off_sphere !== want.off)
                    begin
                        $error("off_sphere: expected %0b, got %0b", want.off,
                               out_ch.off_sphere);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= coord_q.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random directions through the square Lambert block
// under four tolerance settings and three idle patterns, with one long
// result stall; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int                         IO_W      = s2sl_pkg::IO_W;
    localparam logic [s2sl_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int                         DRAIN     = 40;
    localparam int                         LIMIT     = 600000;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [s2sl_pkg::IDX_W-1:0]   cfg_index;
    logic [s2sl_pkg::CFG_W-1:0]   cfg_data;
    int                           fail_count, pending, checked, off_count;
    int                           send_idle, recv_idle, hold_req, cycles;
    int                           n_dirs;

    s2sl_in_if  in_ch ();
    s2sl_out_if out_ch ();

    sphere_to_square_lambert_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    tb_lambert_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .off_count  (off_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_req     <= hold_req - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_dir(input longint x, input longint y, input longint z);
        logic acc;
        begin
            while ($urandom_range(99) < send_idle)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
            in_ch.valid <= 1'b1;
            in_ch.dir_x <= x[IO_W-1:0];
            in_ch.dir_y <= y[IO_W-1:0];
            in_ch.dir_z <= z[IO_W-1:0];
            do
            begin
                @(negedge clk);
                acc = in_ch.ready;
                @(posedge clk);
            end
            while (!acc);
            n_dirs++;
        end
    endtask

    task automatic write_reg(input logic [s2sl_pkg::IDX_W-1:0] idx,
                             input logic [s2sl_pkg::CFG_W-1:0] val);
        begin
            in_ch.valid <= 1'b0;
            // let the last accepted beat show up in the outstanding count
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
            repeat (DRAIN) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // random beat: mostly near-unit vectors, some poles, some raw noise
    task automatic send_random();
        longint a, b, c, lim, rem, t;
        int     kind, rot;
        begin
            kind = $urandom_range(99);
            if (kind < 15)
            begin
                a = longint'($urandom_range(262143)) - 131072;
                b = longint'($urandom_range(262143)) - 131072;
                c = longint'($urandom_range(262143)) - 131072;
                send_dir(a, b, c);
            end
            else if (kind < 25)
            begin
                a = ($urandom_range(3) == 0) ? 0 : longint'($urandom_range(600)) - 300;
                b = ($urandom_range(3) == 0) ? 0 : longint'($urandom_range(600)) - 300;
                c = 65536 - longint'($urandom_range(40)) + longint'($urandom_range(3));
                send_dir(a, b, $urandom_range(1) ? c : -c);
            end
            else
            begin
                a   = longint'($urandom_range(131072)) - 65536;
                lim = $rtoi($sqrt(4294967296.0 - real'(a * a)));
                b   = longint'($urandom_range(2 * lim)) - lim;
                rem = 64'sd4294967296 - a * a - b * b;
                c   = $rtoi($sqrt(real'(rem)) + 0.5);
                if ($urandom_range(7) == 0)
                    c = c + longint'($urandom_range(6)) - 3;
                if ($urandom_range(1))
                    c = -c;
                rot = $urandom_range(2);
                if (rot == 1)
                begin
                    t = a; a = c; c = t;
                end
                else if (rot == 2)
                begin
                    t = b; b = c; c = t;
                end
                send_dir(a, b, c);
            end
        end
    endtask

    task automatic send_directed();
        begin
            send_dir(65536, 0, 0);
            send_dir(-65536, 0, 0);
            send_dir(0, 65536, 0);
            send_dir(0, -65536, 0);
            send_dir(0, 0, 65536);
            send_dir(0, 0, -65536);
            send_dir(0, 0, 0);
            send_dir(131071, 131071, 131071);
            send_dir(-131072, -131072, -131072);
            send_dir(0, 0, 65537);
            send_dir(46341, 46341, 0);
            send_dir(-46341, 46341, 0);
            send_dir(46341, -46341, 0);
            send_dir(37837, 37837, 37837);
            send_dir(-37837, -37837, -37837);
            send_dir(1, 0, 65536);
            send_dir(0, -1, -65536);
            send_dir(256, 0, 65535);
            send_dir(26755, -53510, 26755);
            send_dir(-53510, 26755, -26755);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        in_ch.dir_x  = '0;
        in_ch.dir_y  = '0;
        in_ch.dir_z  = '0;
        out_ch.ready = 1'b0;
        hold_req     = 0;
        cycles       = 0;
        n_dirs       = 0;
        send_idle    = 21;
        recv_idle    = 81;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tolerances, slow receiver
        repeat (300) send_random();

        // loose norm check, exact pole
        write_reg(s2sl_pkg::REG_NORM_TOL, 16'hFFFF);
        write_reg(s2sl_pkg::REG_POLE_TOL, 16'd0);
        write_reg(REG_SPARE, 16'h1234);
        send_directed();
        send_idle = 81;
        recv_idle = 21;
        repeat (400) send_random();

        // strict norm, widest pole band
        write_reg(s2sl_pkg::REG_NORM_TOL, 16'd0);
        write_reg(s2sl_pkg::REG_POLE_TOL, 16'hFFFF);
        send_idle = 0;
        recv_idle = 0;
        repeat (300) send_random();

        // mid settings, long result stall while directions keep coming
        write_reg(s2sl_pkg::REG_NORM_TOL, 16'd30000);
        write_reg(s2sl_pkg::REG_POLE_TOL, 16'd25);
        hold_req <= 200;
        repeat (450) send_random();
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        $display("covered %0d directions, %0d results checked, %0d off the sphere,",
                 n_dirs, checked, off_count);
        $display("under four tolerance settings and three idle patterns");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
